// ----- hdl/dpr_pkg.sv -----
// Shared types and constants for the delimited packet receiver.
package dpr_pkg;

	localparam logic [7:0] PACKET_LEN = 8'd8;

	localparam logic [7:0] HDR_BYTE  = 8'hFF;
	localparam logic [7:0] TAIL_BYTE = 8'hFE;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] FILL_CHAR  = 8'h2A;
	localparam logic [7:0] COUNT_MAX  = 8'hFF;

	// window[31:24] is the oldest byte
	localparam logic [31:0] START_PAT = 32'h434D_4420;
	localparam logic [31:0] END_PAT   = 32'h2045_4E44;

	localparam logic [2:0] END_FULL = 3'd4;
	localparam logic [2:0] END_LAST = 3'd3;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_DATA = 2'd1,
		PH_TAIL = 2'd2
	} bin_phase_t;

	typedef enum logic {
		TS_HUNT = 1'b0,
		TS_RECV = 1'b1
	} text_state_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       frame_start;
		logic       frame_done;
	} dpr_result_t;

endpackage

// ----- hdl/dpr_byte_if.sv -----
// Input channel carrying one received byte per word.
interface dpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/dpr_result_if.sv -----
// Output channel carrying one deframer result per word.
interface dpr_result_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic       frame_start;
	logic       frame_done;

	modport source (output valid, output payload_valid, output payload_byte,
		output payload_index, output frame_start, output frame_done, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input payload_index, input frame_start, input frame_done, output ready);
endinterface

// ----- hdl/delimited_packet_receiver_unit.sv -----
// A byte accepted into the input register gives its result word from the result register.
// Throughput: one byte per cycle while result words are taken; the input register refills while the result
//   register drains, so both stages advance together when the output is taken.
// A result word that is not taken holds the input register once it is full.
// Reset: arst_n clears mode and both deframer states and sets the start window to spaces at once.
// Top level: input register, binary and text deframers, result register.
module delimited_packet_receiver_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	dpr_byte_if.sink     rx,
	dpr_result_if.source result
);
	import dpr_pkg::*;

	logic        text_mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        res_valid_q;
	dpr_result_t res_q;
	dpr_result_t bin_res;
	dpr_result_t txt_res;
	logic        advance;
	logic        step;

	assign advance  = !res_valid_q || result.ready;
	assign rx.ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_mode_q <= 1'b0;
		end else if (cfg_we) begin
			text_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (step) begin
			res_q <= text_mode_q ? txt_res : bin_res;
		end
	end

	dpr_binary_deframer u_bin (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step && !text_mode_q),
		.rx_byte (byte_s1),
		.res     (bin_res)
	);

	dpr_text_deframer u_txt (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step && text_mode_q),
		.rx_byte (byte_s1),
		.res     (txt_res)
	);

	assign result.valid         = res_valid_q;
	assign result.payload_valid = res_q.payload_valid;
	assign result.payload_byte  = res_q.payload_byte;
	assign result.payload_index = res_q.payload_index;
	assign result.frame_start   = res_q.frame_start;
	assign result.frame_done    = res_q.frame_done;

endmodule

// ----- hdl/dpr_binary_deframer.sv -----
// Binary header/payload/tail deframer state and result logic.
module dpr_binary_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output dpr_pkg::dpr_result_t res
);
	import dpr_pkg::*;

	bin_phase_t phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] count_inc;

	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		unique case (phase_q)
			PH_DATA: begin
				count_d = count_inc;
				if (count_inc >= PACKET_LEN) begin
					phase_d = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (rx_byte == TAIL_BYTE) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte == HDR_BYTE) begin
					phase_d = PH_DATA;
					count_d = '0;
				end
			end
		endcase
	end

	always_comb begin
		res = '0;
		unique case (phase_q)
			PH_DATA: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = count_q;
			end
			PH_TAIL: begin
				res.frame_done = 1'b1;
			end
			default: begin
				res.frame_start = (rx_byte == HDR_BYTE);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

endmodule

// ----- hdl/dpr_text_deframer.sv -----
// Text CMD/END deframer: start window, end delay window and byte counter.
module dpr_text_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output dpr_pkg::dpr_result_t res
);
	import dpr_pkg::*;

	text_state_t ts_q, ts_d;
	logic [31:0] start_win_q, start_win_d;
	logic [31:0] end_win_q;
	logic [2:0]  end_fill_q, end_fill_d;
	logic [7:0]  count_q, count_d;
	logic [31:0] start_shift;
	logic [31:0] end_shift;
	logic        start_hit;
	logic        end_full;
	logic        end_hit;

	assign start_shift = {start_win_q[23:0], rx_byte};
	assign end_shift   = {end_win_q[23:0], rx_byte};
	assign start_hit   = (start_shift == START_PAT);
	assign end_full    = (end_fill_q == END_FULL);
	// window is complete after this byte once three are already held
	assign end_hit     = (end_full || end_fill_q == END_LAST) && (end_shift == END_PAT);

	always_comb begin
		ts_d        = ts_q;
		start_win_d = start_win_q;
		end_fill_d  = end_fill_q;
		count_d     = count_q;
		unique case (ts_q)
			TS_HUNT: begin
				start_win_d = start_shift;
				if (start_hit) begin
					ts_d       = TS_RECV;
					end_fill_d = '0;
					count_d    = '0;
				end
			end
			TS_RECV: begin
				if (!end_full) begin
					end_fill_d = end_fill_q + 3'd1;
				end else if (count_q != COUNT_MAX) begin
					count_d = count_q + 8'd1;
				end
				if (end_hit) begin
					ts_d        = TS_HUNT;
					start_win_d = {4{FILL_CHAR}};
				end
			end
			default: ts_d = TS_HUNT;
		endcase
	end

	always_comb begin
		res = '0;
		unique case (ts_q)
			TS_HUNT: begin
				res.frame_start = start_hit;
			end
			TS_RECV: begin
				if (end_full) begin
					res.payload_valid = 1'b1;
					res.payload_byte  = end_win_q[31:24];
					res.payload_index = count_q;
				end
				res.frame_done = end_hit;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q        <= TS_HUNT;
			start_win_q <= {4{SPACE_CHAR}};
			end_fill_q  <= '0;
			count_q     <= '0;
		end else if (step) begin
			ts_q        <= ts_d;
			start_win_q <= start_win_d;
			end_fill_q  <= end_fill_d;
			count_q     <= count_d;
		end
	end

	// contents are only read after three writes
	always_ff @(posedge clk) begin
		if (step && ts_q == TS_RECV) begin
			end_win_q <= end_shift;
		end
	end

endmodule

// ----- hdl/dpr_checker.sv -----
// Port-level checks for the delimited packet receiver, bound to the top level.
module dpr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       payload_valid,
	input logic [7:0] payload_byte,
	input logic [7:0] payload_index,
	input logic       frame_start,
	input logic       frame_done
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload_valid)
		&& $stable(payload_byte) && $stable(payload_index)
		&& $stable(frame_start) && $stable(frame_done))
		else $error("result word changed while stalled");

	a_start_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(frame_start && payload_valid))
		else $error("frame_start with payload");

	a_start_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(frame_start && frame_done))
		else $error("frame_start with frame_done");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 8'd0)
		else $error("payload fields not zero without payload");

endmodule

bind delimited_packet_receiver_unit dpr_checker u_dpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.payload_valid (result.payload_valid),
	.payload_byte  (result.payload_byte),
	.payload_index (result.payload_index),
	.frame_start   (result.frame_start),
	.frame_done    (result.frame_done)
);

// ----- dv/tb_delimited_packet_receiver_unit.sv -----
// Testbench for delimited_packet_receiver_unit: directed table, then framed random bytes.
module tb_delimited_packet_receiver_unit;
	import dpr_pkg::*;

	localparam logic MODE_BINARY = 1'b0;
	localparam logic MODE_TEXT   = 1'b1;
	localparam int SEGMENT_BYTES = 150;
	localparam int HOLD_CYCLES   = 60;
	localparam int CYCLE_LIMIT   = 200000;

	localparam dpr_result_t NO_RESULT  = '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0};
	localparam dpr_result_t START_ONLY = '{1'b0, 8'h00, 8'h00, 1'b1, 1'b0};
	localparam dpr_result_t DONE_ONLY  = '{1'b0, 8'h00, 8'h00, 1'b0, 1'b1};

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_BYTE_KNOWN,
		ROW_MODE
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  val;
		dpr_result_t want;
	} stim_row_t;

	stim_row_t directed_rows [26] = '{
		'{ROW_BYTE_KNOWN, 8'h00, NO_RESULT},
		'{ROW_BYTE_KNOWN, 8'hFE, NO_RESULT},
		'{ROW_BYTE_KNOWN, 8'hFF, START_ONLY},
		'{ROW_BYTE_KNOWN, 8'h00, '{1'b1, 8'h00, 8'd0, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'hFF, '{1'b1, 8'hFF, 8'd1, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'hFE, '{1'b1, 8'hFE, 8'd2, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'h80, '{1'b1, 8'h80, 8'd3, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'h7F, '{1'b1, 8'h7F, 8'd4, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'h55, '{1'b1, 8'h55, 8'd5, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'hAA, '{1'b1, 8'hAA, 8'd6, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'h01, '{1'b1, 8'h01, 8'd7, 1'b0, 1'b0}},
		'{ROW_BYTE_KNOWN, 8'h12, DONE_ONLY},
		'{ROW_BYTE_KNOWN, 8'hFE, DONE_ONLY},
		'{ROW_BYTE_KNOWN, 8'hFF, START_ONLY},
		'{ROW_BYTE_KNOWN, 8'h33, '{1'b1, 8'h33, 8'd0, 1'b0, 1'b0}},
		// switch to text with a binary frame still open
		'{ROW_MODE, 8'(MODE_TEXT), NO_RESULT},
		'{ROW_BYTE, "C", NO_RESULT},
		'{ROW_BYTE, "M", NO_RESULT},
		'{ROW_BYTE, "D", NO_RESULT},
		'{ROW_BYTE, " ", NO_RESULT},
		// empty command: end window fills straight to " END"
		'{ROW_BYTE, " ", NO_RESULT},
		'{ROW_BYTE, "E", NO_RESULT},
		'{ROW_BYTE, "N", NO_RESULT},
		'{ROW_BYTE, "D", NO_RESULT},
		'{ROW_MODE, 8'(MODE_BINARY), NO_RESULT},
		'{ROW_BYTE_KNOWN, 8'h44, '{1'b1, 8'h44, 8'd1, 1'b0, 1'b0}}
	};

	int SRC_IDLE [4]   = '{0, 74, 0, 8};
	int SINK_STALL [4] = '{0, 0, 74, 8};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic hold_req = 1'b0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int err_count = 0;
	int cycle_count = 0;

	// newest at the front, oldest at the back
	dpr_result_t pending_results [$];
	dpr_result_t got_word;
	dpr_result_t want_word;

	// predictor state
	logic        mode_q = MODE_BINARY;
	bin_phase_t  bin_phase = PH_HUNT;
	logic [7:0]  bin_count = 8'h00;
	text_state_t text_state = TS_HUNT;
	logic [31:0] start_win = {4{SPACE_CHAR}};
	logic [31:0] end_win = 32'h0;
	logic [2:0]  end_fill = 3'd0;
	logic [7:0]  text_count = 8'h00;

	dpr_byte_if   byte_ch ();
	dpr_result_if word_ch ();

	delimited_packet_receiver_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (byte_ch),
		.result    (word_ch)
	);

	always #1 clk = ~clk;

	function automatic dpr_result_t deframe_byte(input logic [7:0] b);
		dpr_result_t r;
		r = NO_RESULT;
		if (mode_q == MODE_BINARY) begin
			case (bin_phase)
				PH_DATA: begin
					r.payload_valid = 1'b1;
					r.payload_byte = b;
					r.payload_index = bin_count;
					bin_count = bin_count + 8'd1;
					if (bin_count >= PACKET_LEN)
						bin_phase = PH_TAIL;
				end
				PH_TAIL: begin
					r.frame_done = 1'b1;
					if (b == TAIL_BYTE)
						bin_phase = PH_HUNT;
				end
				default: begin
					bin_phase = PH_HUNT;
					if (b == HDR_BYTE) begin
						bin_phase = PH_DATA;
						bin_count = 8'h00;
						r.frame_start = 1'b1;
					end
				end
			endcase
		end else if (text_state == TS_HUNT) begin
			start_win = {start_win[23:0], b};
			if (start_win == START_PAT) begin
				text_state = TS_RECV;
				end_fill = 3'd0;
				text_count = 8'h00;
				r.frame_start = 1'b1;
			end
		end else begin
			if (end_fill < END_FULL) begin
				end_win[8 * (END_LAST - end_fill) +: 8] = b;
				end_fill = end_fill + 3'd1;
			end else begin
				r.payload_valid = 1'b1;
				r.payload_byte = end_win[31:24];
				r.payload_index = text_count;
				if (text_count != COUNT_MAX)
					text_count = text_count + 8'd1;
				end_win = {end_win[23:0], b};
			end
			if (end_fill >= END_FULL && end_win == END_PAT) begin
				text_state = TS_HUNT;
				r.frame_done = 1'b1;
				start_win = {4{FILL_CHAR}};
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			err_count++;
		end
	endfunction

	function automatic logic [7:0] pick_text_char();
		string letters;
		letters = "CMDEN";
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, 255));
			1: return SPACE_CHAR;
			2: return letters[$urandom_range(0, 4)];
			default: return 8'($urandom_range(33, 126));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit known = 1'b0,
			input dpr_result_t want = NO_RESULT);
		dpr_result_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.rx_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		predicted = deframe_byte(b);
		pending_results.push_front(known ? want : predicted);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++)
			send_byte(s[k]);
	endtask

	task automatic wait_results_drained();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_text_mode(input logic m);
		wait_results_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_q = m;
	endtask

	task automatic gen_binary_frame();
		logic [7:0] b;
		repeat ($urandom_range(0, 2))
			send_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			return;
		send_byte(HDR_BYTE);
		repeat (PACKET_LEN)
			send_byte(8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 3)) begin
			b = 8'($urandom_range(0, 255));
			if (b == TAIL_BYTE)
				b = HDR_BYTE;
			send_byte(b);
		end
		send_byte(TAIL_BYTE);
	endtask

	task automatic gen_text_frame(input int body_len);
		repeat ($urandom_range(0, 4))
			send_byte(pick_text_char());
		case ($urandom_range(0, 9))
			0: send_text("CM");
			1: send_text("CMD");
			default: begin
				send_text("CMD ");
				repeat (body_len)
					send_byte(pick_text_char());
				send_text(" END");
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			word_ch.ready <= 1'b0;
		end else begin
			word_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_ch.valid && word_ch.ready) begin
			got_word = '{word_ch.payload_valid, word_ch.payload_byte, word_ch.payload_index,
				word_ch.frame_start, word_ch.frame_done};
			if (pending_results.size() == 0) begin
				$error("result word with no byte pending");
				err_count++;
			end else begin
				want_word = pending_results.pop_back();
				check_field("payload_valid", 8'(want_word.payload_valid),
					8'(got_word.payload_valid));
				check_field("payload_byte", want_word.payload_byte, got_word.payload_byte);
				check_field("payload_index", want_word.payload_index, got_word.payload_index);
				check_field("frame_start", 8'(want_word.frame_start), 8'(got_word.frame_start));
				check_field("frame_done", 8'(want_word.frame_done), 8'(got_word.frame_done));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int seg_start;
		logic seg_mode;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = 8'h00;
		word_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_MODE: set_text_mode(directed_rows[i].val[0]);
				ROW_BYTE_KNOWN: send_byte(directed_rows[i].val, 1'b1, directed_rows[i].want);
				default: send_byte(directed_rows[i].val);
			endcase
		end

		for (int p = 0; p < 4; p++) begin
			src_idle_pct = SRC_IDLE[p];
			sink_stall_pct = SINK_STALL[p];
			for (int m = 0; m < 2; m++) begin
				seg_mode = (m % 2 == p % 2) ? MODE_BINARY : MODE_TEXT;
				set_text_mode(seg_mode);
				seg_start = bytes_sent;
				// output held off while input keeps streaming
				if (p == 0 && m == 0)
					hold_req <= 1'b1;
				if (seg_mode == MODE_TEXT && (p == 0 || p == 3))
					gen_text_frame($urandom_range(270, 300));
				while (bytes_sent - seg_start < SEGMENT_BYTES) begin
					if (p == 1 && m == 0 && bytes_sent - seg_start == SEGMENT_BYTES / 2)
						wait_results_drained();
					if (seg_mode == MODE_BINARY)
						gen_binary_frame();
					else
						gen_text_frame($urandom_range(0, 12));
				end
				// leave a frame open across the mode change
				if ($urandom_range(0, 1) == 1) begin
					if (seg_mode == MODE_BINARY)
						send_byte(HDR_BYTE);
					else
						send_text("CMD ");
					repeat ($urandom_range(0, 6))
						send_byte(8'($urandom_range(0, 255)));
				end
			end
		end

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
